/* rtl/fcvd_pkg.sv */
package fcvd_pkg;

  localparam int unsigned MAX_WORD_LEN_DEF = 255;

  // Header lengths in bytes for each format
  localparam logic [8:0] HdrLenFmt0 = 9'(26 * 2);
  localparam logic [8:0] HdrLenFmt1 = 9'(255 * 2);

  localparam logic [7:0] CharMask  = 8'h7f;
  localparam logic [7:0] TermBit   = 8'h80;
  localparam logic [7:0] HighNib   = 8'hf0;
  localparam logic [7:0] LowNib    = 8'h0f;
  localparam logic [15:0] EntryMax = 16'hffff;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_PREFIX  = 5'b00010,
    PH_WORD    = 5'b00100,
    PH_TRAILER = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_ENTRY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_HDR_SHORT = 2'd1,
    ERR_TRAILER   = 2'd2,
    ERR_IN_WORD   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    TR_B0 = 2'd0,
    TR_B1 = 2'd1,
    TR_B2 = 2'd2
  } trailer_step_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  char_value;
    logic [7:0]  char_position;
    logic [7:0]  word_length;
    logic [11:0] word_class;
    logic [11:0] word_group;
    logic [15:0] entry_index;
    err_t        error_code;
    logic        stream_done;
  } result_t;

endpackage

/* rtl/fcvd_in_stage.sv */
module fcvd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte,
  output logic       stage_eos
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       eos_r;

  assign in_tready   = !valid_r || advance;
  assign stage_valid = valid_r;
  assign stage_byte  = byte_r;
  assign stage_eos   = eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
      eos_r  <= in_eos;
    end
  end

endmodule

/* rtl/fcvd_decode.sv */
module fcvd_decode #(
  parameter int unsigned MAX_WORD_LEN = fcvd_pkg::MAX_WORD_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              eos,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output logic              res_valid,
  output fcvd_pkg::result_t res
);

  localparam logic [7:0] MaxLen = 8'(MAX_WORD_LEN);

  fcvd_pkg::phase_t        phase_r, phase_nxt;
  fcvd_pkg::trailer_step_t step_r, step_nxt;
  logic       format_r;
  logic [8:0] header_left_r, header_left_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] class_hi_r, class_hi_nxt;
  logic [7:0] mid_r, mid_nxt;
  logic [15:0] entries_r, entries_nxt;

  logic [8:0] hl_dec;
  logic [7:0] clamp;
  logic [7:0] pos_inc;
  logic       emit;

  always_comb begin
    phase_nxt       = phase_r;
    step_nxt        = step_r;
    header_left_nxt = header_left_r;
    pos_nxt         = pos_r;
    class_hi_nxt    = class_hi_r;
    mid_nxt         = mid_r;
    entries_nxt     = entries_r;
    res_valid       = 1'b0;
    res             = '0;
    hl_dec          = (header_left_r != 9'd0) ? header_left_r - 9'd1 : header_left_r;
    clamp           = (data_byte > MaxLen) ? MaxLen : data_byte;
    emit            = (pos_r < MaxLen);
    pos_inc         = emit ? pos_r + 8'd1 : pos_r;

    if (fire) begin
      unique case (phase_r)
        fcvd_pkg::PH_HEADER: begin
          header_left_nxt = hl_dec;
          if (hl_dec == 9'd0) begin
            phase_nxt = eos ? fcvd_pkg::PH_DONE : fcvd_pkg::PH_PREFIX;
          end else if (eos) begin
            res_valid        = 1'b1;
            res.result_kind  = fcvd_pkg::KIND_ERROR;
            res.error_code   = fcvd_pkg::ERR_HDR_SHORT;
            res.stream_done  = 1'b1;
            phase_nxt        = fcvd_pkg::PH_DONE;
          end
        end
        fcvd_pkg::PH_PREFIX: begin
          pos_nxt = clamp;
          if (eos) begin
            res_valid        = 1'b1;
            res.result_kind  = fcvd_pkg::KIND_ERROR;
            res.error_code   = fcvd_pkg::ERR_IN_WORD;
            res.stream_done  = 1'b1;
            phase_nxt        = fcvd_pkg::PH_DONE;
          end else if (format_r && clamp >= MaxLen) begin
            phase_nxt = fcvd_pkg::PH_TRAILER;
            step_nxt  = fcvd_pkg::TR_B0;
          end else begin
            phase_nxt = fcvd_pkg::PH_WORD;
          end
        end
        fcvd_pkg::PH_WORD: begin
          if (eos) begin
            res_valid        = 1'b1;
            res.result_kind  = fcvd_pkg::KIND_ERROR;
            res.error_code   = (!format_r && (data_byte & fcvd_pkg::TermBit) != 8'd0) ?
                               fcvd_pkg::ERR_TRAILER : fcvd_pkg::ERR_IN_WORD;
            res.stream_done  = 1'b1;
            phase_nxt        = fcvd_pkg::PH_DONE;
          end else if (format_r) begin
            if (data_byte == 8'd0) begin
              phase_nxt = fcvd_pkg::PH_TRAILER;
              step_nxt  = fcvd_pkg::TR_B0;
            end else begin
              res_valid         = emit;
              res.result_kind   = fcvd_pkg::KIND_CHAR;
              res.char_value    = emit ? data_byte : 8'd0;
              res.char_position = emit ? pos_r : 8'd0;
              pos_nxt           = pos_inc;
              if (pos_inc >= MaxLen) begin
                phase_nxt = fcvd_pkg::PH_TRAILER;
                step_nxt  = fcvd_pkg::TR_B0;
              end
            end
          end else begin
            res_valid         = emit;
            res.result_kind   = fcvd_pkg::KIND_CHAR;
            res.char_value    = emit ? (data_byte & fcvd_pkg::CharMask) : 8'd0;
            res.char_position = emit ? pos_r : 8'd0;
            pos_nxt           = pos_inc;
            if ((data_byte & fcvd_pkg::TermBit) != 8'd0) begin
              phase_nxt = fcvd_pkg::PH_TRAILER;
              step_nxt  = fcvd_pkg::TR_B0;
            end
          end
        end
        fcvd_pkg::PH_TRAILER: begin
          if (step_r == fcvd_pkg::TR_B0 || step_r == fcvd_pkg::TR_B1) begin
            if (step_r == fcvd_pkg::TR_B0) begin
              class_hi_nxt = data_byte;
              step_nxt     = fcvd_pkg::TR_B1;
            end else begin
              mid_nxt  = data_byte;
              step_nxt = fcvd_pkg::TR_B2;
            end
            if (eos) begin
              res_valid        = 1'b1;
              res.result_kind  = fcvd_pkg::KIND_ERROR;
              res.error_code   = fcvd_pkg::ERR_TRAILER;
              res.stream_done  = 1'b1;
              phase_nxt        = fcvd_pkg::PH_DONE;
            end
          end else begin
            entries_nxt      = (entries_r != fcvd_pkg::EntryMax) ? entries_r + 16'd1 : entries_r;
            res_valid        = 1'b1;
            res.result_kind  = fcvd_pkg::KIND_ENTRY;
            res.word_length  = pos_r;
            res.word_class   = {class_hi_r, 4'((mid_r & fcvd_pkg::HighNib) >> 4)};
            res.word_group   = {4'(mid_r & fcvd_pkg::LowNib), data_byte};
            res.entry_index  = entries_nxt;
            res.stream_done  = eos;
            step_nxt         = fcvd_pkg::TR_B0;
            phase_nxt        = eos ? fcvd_pkg::PH_DONE : fcvd_pkg::PH_PREFIX;
          end
        end
        fcvd_pkg::PH_DONE: begin
          phase_nxt = fcvd_pkg::PH_DONE;
        end
        default: begin
          phase_nxt = fcvd_pkg::PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= fcvd_pkg::PH_HEADER;
      step_r        <= fcvd_pkg::TR_B0;
      format_r      <= 1'b0;
      header_left_r <= fcvd_pkg::HdrLenFmt0;
      pos_r         <= 8'd0;
      class_hi_r    <= 8'd0;
      mid_r         <= 8'd0;
      entries_r     <= 16'd0;
    end else if (cfg_we) begin
      format_r <= cfg_wdata;
      if (phase_r == fcvd_pkg::PH_HEADER) begin
        header_left_r <= cfg_wdata ? fcvd_pkg::HdrLenFmt1 : fcvd_pkg::HdrLenFmt0;
      end
    end else begin
      phase_r       <= phase_nxt;
      step_r        <= step_nxt;
      header_left_r <= header_left_nxt;
      pos_r         <= pos_nxt;
      class_hi_r    <= class_hi_nxt;
      mid_r         <= mid_nxt;
      entries_r     <= entries_nxt;
    end
  end

endmodule

/* rtl/fcvd_out_stage.sv */
module fcvd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  fcvd_pkg::result_t res,
  input  logic              out_tready,
  output logic              out_tvalid,
  output fcvd_pkg::result_t out_res
);

  logic              valid_r;
  fcvd_pkg::result_t res_r;

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/front_coded_vocab_decoder.sv */
// Path: a byte accepted into the input register is decoded when it fires, and its
// result is captured in the result register (input register, then decode into the
// result register), from which the result transaction is offered.
// Throughput: one byte per cycle sustained; the only limit is the result register
// draining, so a stalled result holds back the input stage behind it.
// Reset: rst_n is synchronous, active low; it restores the header skip for format 0.
module front_coded_vocab_decoder #(
  parameter int unsigned MAX_WORD_LEN = fcvd_pkg::MAX_WORD_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Format register write port
  input  logic        cfg_we,
  input  logic        cfg_wdata,    // format_mode
  // Resource byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tlast,     // end_of_stream
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] char_value, [15:8] char_position, [23:16] word_length,
  // [35:24] word_class, [47:36] word_group, [63:48] entry_index,
  // [65:64] error_code, [71:66] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,    // [1:0] result_kind
  output logic        out_tlast     // stream_done
);

  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic              stage_eos;
  logic              advance;
  logic              fire;
  logic              res_valid;
  fcvd_pkg::result_t res;
  fcvd_pkg::result_t out_res;

  // The held byte may move on whenever the result slot is free or draining this
  // cycle; bytes that produce no result then simply pass through the state update.
  assign advance = !out_tvalid || out_tready;
  assign fire    = stage_valid && advance;

  fcvd_in_stage u_in (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_byte     (in_tdata),
    .in_eos      (in_tlast),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte),
    .stage_eos   (stage_eos)
  );

  // Phase tracking, header count, word position, trailer capture and the
  // entry counter all live here and advance once per fired byte.
  fcvd_decode #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (stage_byte),
    .eos       (stage_eos),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // Capture a result only when the decode produced one for a fired byte.
  fcvd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res_valid),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  // Pack the held result onto the stream ports.
  assign out_tdata = {6'd0, out_res.error_code, out_res.entry_index, out_res.word_group,
                      out_res.word_class, out_res.word_length, out_res.char_position,
                      out_res.char_value};
  assign out_tuser = out_res.result_kind;
  assign out_tlast = out_res.stream_done;

`ifndef ASSERT_OFF
  // A fired byte never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_valid && out_tvalid) |-> out_tready)
    else $error("result register overwritten");

  // Once the closing transaction is taken, no further result appears.
  a_quiet_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after stream close");

  // Input back-pressure only comes from a held byte that cannot move.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (stage_valid && out_tvalid && !out_tready))
    else $error("input stalled without cause");
`endif

endmodule

/* test/fcvd_checker.sv */
`timescale 1ns / 100ps

module fcvd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tlast,     // end_of_stream
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] char_value, [15:8] char_position, [23:16] word_length,
  // [35:24] word_class, [47:36] word_group, [63:48] entry_index,
  // [65:64] error_code, [71:66] zero
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,    // [1:0] result_kind
  input  logic        out_tlast,    // stream_done
  output int          fail_count,
  output int          pending,
  output int          char_seen,
  output int          entry_seen,
  output int          error_seen
);

  localparam int unsigned WordMax   = fcvd_pkg::MAX_WORD_LEN_DEF;
  localparam int          ReportMax = 10;

  // Decoder state as the predictor sees it
  fcvd_pkg::phase_t        ph;
  logic                    fmt;
  logic [8:0]              hdr_left;
  int unsigned             wpos;
  fcvd_pkg::trailer_step_t tstep;
  logic [7:0]              cls_hi;
  logic [7:0]              mid;
  logic [15:0]             entries;

  fcvd_pkg::result_t expected_q[$];

  task automatic clear_decoder();
    ph       = fcvd_pkg::PH_HEADER;
    fmt      = 1'b0;
    hdr_left = fcvd_pkg::HdrLenFmt0;
    wpos     = 0;
    tstep    = fcvd_pkg::TR_B0;
    cls_hi   = '0;
    mid      = '0;
    entries  = '0;
  endtask

  task automatic raise_error(input fcvd_pkg::err_t code, output bit got,
                             output fcvd_pkg::result_t r);
    r             = '0;
    r.result_kind = fcvd_pkg::KIND_ERROR;
    r.error_code  = code;
    r.stream_done = 1'b1;
    got           = 1'b1;
    ph            = fcvd_pkg::PH_DONE;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eos,
                             output bit got, output fcvd_pkg::result_t r);
    got = 1'b0;
    r   = '0;
    case (ph)
      fcvd_pkg::PH_HEADER: begin
        if (hdr_left != 0) hdr_left = hdr_left - 9'd1;
        if (hdr_left == 0) ph = eos ? fcvd_pkg::PH_DONE : fcvd_pkg::PH_PREFIX;
        else if (eos) raise_error(fcvd_pkg::ERR_HDR_SHORT, got, r);
      end
      fcvd_pkg::PH_PREFIX: begin
        wpos = (32'(b) > WordMax) ? WordMax : 32'(b);
        if (eos) begin
          raise_error(fcvd_pkg::ERR_IN_WORD, got, r);
        end else if (fmt && wpos >= WordMax) begin
          ph    = fcvd_pkg::PH_TRAILER;
          tstep = fcvd_pkg::TR_B0;
        end else begin
          ph = fcvd_pkg::PH_WORD;
        end
      end
      fcvd_pkg::PH_WORD: begin
        if (eos) begin
          raise_error((!fmt && (b & fcvd_pkg::TermBit) != 0) ? fcvd_pkg::ERR_TRAILER
                                                              : fcvd_pkg::ERR_IN_WORD,
                      got, r);
        end else if (fmt && b == 8'h00) begin
          ph    = fcvd_pkg::PH_TRAILER;
          tstep = fcvd_pkg::TR_B0;
        end else begin
          if (wpos < WordMax) begin
            got             = 1'b1;
            r.result_kind   = fcvd_pkg::KIND_CHAR;
            r.char_value    = fmt ? b : (b & fcvd_pkg::CharMask);
            r.char_position = wpos[7:0];
            wpos++;
          end
          if (fmt ? (wpos >= WordMax) : ((b & fcvd_pkg::TermBit) != 0)) begin
            ph    = fcvd_pkg::PH_TRAILER;
            tstep = fcvd_pkg::TR_B0;
          end
        end
      end
      fcvd_pkg::PH_TRAILER: begin
        case (tstep)
          fcvd_pkg::TR_B0: begin
            cls_hi = b;
            if (eos) raise_error(fcvd_pkg::ERR_TRAILER, got, r);
            else tstep = fcvd_pkg::TR_B1;
          end
          fcvd_pkg::TR_B1: begin
            mid = b;
            if (eos) raise_error(fcvd_pkg::ERR_TRAILER, got, r);
            else tstep = fcvd_pkg::TR_B2;
          end
          default: begin
            if (entries != fcvd_pkg::EntryMax) entries++;
            got           = 1'b1;
            r.result_kind = fcvd_pkg::KIND_ENTRY;
            r.word_length = wpos[7:0];
            r.word_class  = {cls_hi, mid[7:4]};
            r.word_group  = {mid[3:0], b};
            r.entry_index = entries;
            r.stream_done = eos;
            tstep         = fcvd_pkg::TR_B0;
            ph            = eos ? fcvd_pkg::PH_DONE : fcvd_pkg::PH_PREFIX;
          end
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic string show(fcvd_pkg::result_t r);
    return $sformatf({"kind=%0d char=%02h pos=%0d len=%0d class=%03h group=%03h ",
                      "index=%0d err=%0d done=%0b"},
                     r.result_kind, r.char_value, r.char_position, r.word_length,
                     r.word_class, r.word_group, r.entry_index, r.error_code, r.stream_done);
  endfunction

  always @(posedge clk) begin
    fcvd_pkg::result_t act;
    fcvd_pkg::result_t want;
    fcvd_pkg::result_t pred;
    bit                hit;
    if (!rst_n) begin
      clear_decoder();
      expected_q.delete();
      fail_count = 0;
      char_seen  = 0;
      entry_seen = 0;
      error_seen = 0;
    end else begin
      if (cfg_we) begin
        fmt = cfg_wdata;
        if (ph == fcvd_pkg::PH_HEADER) begin
          hdr_left = fmt ? fcvd_pkg::HdrLenFmt1 : fcvd_pkg::HdrLenFmt0;
        end
      end
      if (out_tvalid && out_tready) begin
        act.result_kind   = fcvd_pkg::kind_t'(out_tuser);
        act.char_value    = out_tdata[7:0];
        act.char_position = out_tdata[15:8];
        act.word_length   = out_tdata[23:16];
        act.word_class    = out_tdata[35:24];
        act.word_group    = out_tdata[47:36];
        act.entry_index   = out_tdata[63:48];
        act.error_code    = fcvd_pkg::err_t'(out_tdata[65:64]);
        act.stream_done   = out_tlast;
        case (act.result_kind)
          fcvd_pkg::KIND_CHAR:  char_seen++;
          fcvd_pkg::KIND_ENTRY: entry_seen++;
          default:              error_seen++;
        endcase
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax)
            $display("%0t: unexpected result: %s", $realtime, show(act));
        end else begin
          want = expected_q.pop_front();
          if (act.result_kind   !== want.result_kind   ||
              act.char_value    !== want.char_value    ||
              act.char_position !== want.char_position ||
              act.word_length   !== want.word_length   ||
              act.word_class    !== want.word_class    ||
              act.word_group    !== want.word_group    ||
              act.entry_index   !== want.entry_index   ||
              act.error_code    !== want.error_code    ||
              act.stream_done   !== want.stream_done   ||
              out_tdata[71:66]  !== 6'd0) begin
            fail_count++;
            if (fail_count <= ReportMax) begin
              $display("%0t: mismatch, expected %s", $realtime, show(want));
              $display("%0t:           actual   %s pad=%02h", $realtime, show(act),
                       out_tdata[71:66]);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata, in_tlast, hit, pred);
        if (hit) expected_q.insert(expected_q.size(), pred);
      end
    end
    pending <= expected_q.size();
  end

endmodule

/* test/tb_front_coded_vocab_decoder.sv */
`timescale 1ns / 100ps

module tb_front_coded_vocab_decoder;

  localparam int WordMax      = int'(fcvd_pkg::MAX_WORD_LEN_DEF);
  localparam int GapMax       = 11;
  localparam int SettleWait   = 4;      // drain margin after the last result
  localparam int HoldCycles   = 300;    // long receiver hold-off
  localparam int StallLimit   = 4000;   // cycles with no transaction at all
  localparam int BurstEntries = 16;     // minimal entries sent back to back
  localparam int RandomBytes  = 250;    // first random section
  localparam int TotalBytes   = 1100;   // minimum bytes sent over the whole run

  // How the stream is closed; one per run, since reset comes only once
  typedef enum int {
    END_HDR_SHORT,
    END_EMPTY,
    END_CLOSE,
    END_PREFIX,
    END_IN_WORD,
    END_ON_TERM,
    END_TRAIL_B0,
    END_TRAIL_B1
  } ending_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending;
  int char_seen;
  int entry_seen;
  int error_seen;

  // Sender-side bookkeeping
  bit         burst     = 1'b0;  // no idling on either side while set
  int         hold_req  = 0;     // bump to ask the receiver for one long hold-off
  logic       fmt_now   = 1'b0;
  logic       hdr_fmt;
  ending_t    ending;
  logic [7:0] entry_q[$];        // bytes of the entry being sent
  int         term_at;           // index of the word terminator, -1 if none
  int         n_sent    = 0;
  int         stall     = 0;

  always #1 clk = ~clk;

  front_coded_vocab_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  fcvd_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .char_seen  (char_seen),
    .entry_seen (entry_seen),
    .error_seen (error_seen)
  );

  // Watchdog: end the run when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall <= 0;
    end else if (stall == StallLimit) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               StallLimit, pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  // Result side: draw an idle gap per transaction, or hold off for a long
  // stretch once when the sender asks, so the block backs up into its input.
  initial begin : result_sink
    int gap;
    int served;
    served = 0;
    forever begin
      if (hold_req != served) begin
        gap    = HoldCycles;
        served = hold_req;
      end else begin
        gap = burst ? 0 : $urandom_range(0, GapMax);
      end
      if (gap > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Offer one byte after a random gap and hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, GapMax);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid, wait until every predicted result has been taken, then let
  // the pipeline empty out bytes that produce no result. Ends at a falling edge.
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  task automatic set_format(input logic v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk) cfg_we <= 1'b0;
    fmt_now = v;
  endtask

  task automatic append_byte(input logic [7:0] v);
    entry_q.insert(entry_q.size(), v);
  endtask

  // Lay out one entry for the current format: prefix, characters, terminator
  // where the word needs one, then the three trailer bytes.
  task automatic build_entry(input logic [7:0] prefix, input int nchars, input bit ext,
                             input logic [23:0] trl);
    int pos;
    entry_q.delete();
    term_at = -1;
    append_byte(prefix);
    pos = int'(prefix);
    if (fmt_now) begin
      // a word that reaches the limit runs straight into its trailer
      for (int k = 0; k < nchars && pos < WordMax; k++) begin
        append_byte(ext ? ((k % 2) ? 8'hff : 8'h01) : 8'($urandom_range(1, 255)));
        pos++;
      end
      if (pos < WordMax) begin
        term_at = entry_q.size();
        append_byte(8'h00);
      end
    end else begin
      for (int k = 0; k < nchars; k++)
        append_byte(ext ? ((k % 2) ? 8'h7f : 8'h00) : 8'($urandom_range(0, 127)));
      term_at = entry_q.size();
      append_byte(ext ? ((nchars % 2) ? 8'hff : 8'h80)
                      : (8'h80 | 8'($urandom_range(0, 127))));
    end
    append_byte(trl[23:16]);
    append_byte(trl[15:8]);
    append_byte(trl[7:0]);
  endtask

  // Send the laid-out entry; mark byte cut as the last one and stop there.
  task automatic put_entry(input int cut);
    for (int i = 0; i < entry_q.size(); i++) begin
      send_byte(entry_q[i], i == cut);
      if (i == cut) break;
    end
  endtask

  task automatic entry(input logic [7:0] prefix, input int nchars, input bit ext,
                       input logic [23:0] trl);
    build_entry(prefix, nchars, ext, trl);
    put_entry(-1);
  endtask

  // Mostly short words with small prefixes, now and then a word past the
  // length limit or a prefix at or near it.
  task automatic random_entry();
    int         n;
    logic [7:0] prefix;
    n = ($urandom_range(0, 99) < 4) ? $urandom_range(250, 300) : $urandom_range(0, 12);
    case ($urandom_range(0, 19))
      0:       prefix = 8'(WordMax);
      1:       prefix = 8'($urandom_range(240, WordMax - 1));
      default: prefix = 8'($urandom_range(0, 8));
    endcase
    entry(prefix, n, 1'b0, 24'($urandom));
  endtask

  // Send random entries until the byte count reaches goal.
  task automatic random_section(input bit with_hold, input int goal);
    int count;
    count = 0;
    while (n_sent < goal) begin
      if ($urandom_range(0, 39) == 0) set_format(1'($urandom_range(0, 1)));
      burst = ($urandom_range(0, 9) == 0);
      if (with_hold && count == 0) begin
        // hold the result side off while a long word keeps coming
        burst = 1'b0;
        hold_req++;
        entry(8'd0, 60, 1'b0, 24'($urandom));
      end else begin
        random_entry();
      end
      count++;
    end
    burst = 1'b0;
  endtask

  initial begin : stimulus
    int r;
    int hdr_len;
    int cut;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Start the header in one format, then switch: the header count reloads.
    hdr_fmt = 1'($urandom_range(0, 1));
    set_format(!hdr_fmt);
    repeat (5) send_byte(8'($urandom), 1'b0);
    set_format(hdr_fmt);
    hdr_len = hdr_fmt ? int'(fcvd_pkg::HdrLenFmt1) : int'(fcvd_pkg::HdrLenFmt0);

    r      = $urandom_range(0, 15);
    ending = (r == 0) ? END_HDR_SHORT :
             (r == 1) ? END_EMPTY : ending_t'(END_CLOSE + (r - 2) % 6);

    if (ending == END_HDR_SHORT) begin
      case ($urandom_range(0, 2))
        0:       cut = 1;
        1:       cut = hdr_len - 1;
        default: cut = $urandom_range(1, hdr_len - 1);
      endcase
      for (int i = 0; i < cut; i++) send_byte(8'($urandom), i == cut - 1);
    end else begin
      for (int i = 0; i < hdr_len; i++)
        send_byte(8'($urandom), ending == END_EMPTY && i == hdr_len - 1);
      if (ending != END_EMPTY) begin
        // Directed entries in both formats: empty word, extreme characters
        // with the widest class and group, and a prefix at the word limit.
        for (int pass = 0; pass < 2; pass++) begin
          entry(8'd0, 0, 1'b1, 24'h000000);
          entry(8'd3, 2, 1'b1, 24'hffffff);
          entry(8'(WordMax), 2, 1'b1, 24'h5a0f3c);
          if (pass == 0) set_format(!fmt_now);
        end

        random_section(1'b1, n_sent + RandomBytes);

        // Run minimal entries back to back with no idling on either side.
        set_format(1'b1);
        burst = 1'b1;
        for (int i = 0; i < BurstEntries; i++) entry(8'(WordMax), 0, 1'b0, 24'($urandom));
        burst = 1'b0;
        set_format(1'($urandom_range(0, 1)));

        random_section(1'b0, TotalBytes - 40);

        // Close the stream at the chosen place in one last entry.
        build_entry(8'($urandom_range(0, 5)), $urandom_range(1, 8), 1'b0, 24'($urandom));
        case (ending)
          END_PREFIX:   cut = 0;
          END_IN_WORD:  cut = $urandom_range(1, entry_q.size() - 5);
          END_ON_TERM:  cut = term_at;
          END_TRAIL_B0: cut = entry_q.size() - 3;
          END_TRAIL_B1: cut = entry_q.size() - 2;
          default:      cut = entry_q.size() - 1;
        endcase
        put_entry(cut);
      end
    end

    // Bytes after the close must be swallowed without a result.
    for (int i = 0; i < 6 || n_sent < TotalBytes; i++)
      send_byte(8'($urandom), 1'($urandom_range(0, 1)));

    settle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input bytes, header in format %0d, stream end: %s",
             n_sent, hdr_fmt, ending.name());
    $display("Checked %0d character, %0d entry and %0d error results, %0d mismatches",
             char_seen, entry_seen, error_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
